FILE: rtl/pcsf_pkg.sv
// ----------------------------------------------------------------------------
// pcsf_pkg
// Shared widths, constants and stage records of the pair contact spring
// force pipeline.
// ----------------------------------------------------------------------------
package pcsf_pkg;

  // Dimensionality of the contact: 2 ignores z, anything else is 3D.
  localparam int unsigned DIMENSIONS = 3;

  localparam int unsigned CW     = 32;           // coordinate and force width
  localparam int unsigned RW     = 31;           // radius width
  localparam int unsigned KW     = 32;           // spring constant width
  localparam int unsigned MW     = CW + 1;       // offset magnitude width
  localparam int unsigned SW     = 2 * MW;       // sum of squares width
  localparam int unsigned ROOTW  = MW;           // distance width
  localparam int unsigned REMW   = ROOTW + 2;    // root remainder width
  localparam int unsigned UW     = 31;           // unit component width, Q1.30
  localparam int unsigned DREMW  = ROOTW + 1;    // divider remainder width
  localparam int unsigned DRESTW = UW;           // numerator bits still to shift in
  localparam int unsigned PW     = 2 * KW;       // |delta| * k width
  localparam int unsigned PPW    = KW + UW;      // partial product width
  localparam int unsigned FPW    = PW + UW;      // full product width
  localparam int unsigned QW     = FPW - 46;     // product after the Q shift

  localparam int unsigned SQRT_STEPS = ROOTW;
  localparam int unsigned DIV_STEPS  = UW;

  localparam logic [KW-1:0] SPRING_RESET = KW'(65536);
  localparam logic [QW-1:0] POS_LIMIT    = QW'(64'h7FFF_FFFF);
  localparam logic [QW-1:0] NEG_LIMIT    = QW'(64'h8000_0000);

  // Pair geometry carried through the root stages.
  typedef struct packed {
    logic [2:0][MW-1:0] mag;
    logic [2:0]         neg;
    logic [RW:0]        rsum;
  } geom_t;

  // One step of the square root.
  typedef struct packed {
    geom_t              geom;
    logic [SW-1:0]      rad;
    logic [ROOTW-1:0]   root;
    logic [REMW-1:0]    rem;
  } sqrt_t;

  // One step of the three unit-vector dividers.
  typedef struct packed {
    logic [2:0][DREMW-1:0]  rem;
    logic [2:0][DRESTW-1:0] rest;
    logic [2:0][UW-1:0]     quo;
    logic [ROOTW-1:0]       span;
    logic [PW-1:0]          pmag;
    logic [2:0]             neg;
    logic                   collided;
    logic                   zero;
  } div_t;

endpackage

FILE: rtl/pcsf_pair_if.sv
// ----------------------------------------------------------------------------
// pcsf_pair_if
// Particle pair channel: two centroids and two radii per transaction.
// ----------------------------------------------------------------------------
interface pcsf_pair_if;
  logic              valid;
  logic              ready;
  logic signed [31:0] first_x;
  logic signed [31:0] first_y;
  logic signed [31:0] first_z;
  logic        [30:0] first_radius;
  logic signed [31:0] second_x;
  logic signed [31:0] second_y;
  logic signed [31:0] second_z;
  logic        [30:0] second_radius;

  modport source (
    output valid, first_x, first_y, first_z, first_radius,
    output second_x, second_y, second_z, second_radius,
    input  ready
  );
  modport sink (
    input  valid, first_x, first_y, first_z, first_radius,
    input  second_x, second_y, second_z, second_radius,
    output ready
  );
endinterface

FILE: rtl/pcsf_force_if.sv
// ----------------------------------------------------------------------------
// pcsf_force_if
// Contact force channel: force vector and contact flag per transaction.
// ----------------------------------------------------------------------------
interface pcsf_force_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] force_x;
  logic signed [31:0] force_y;
  logic signed [31:0] force_z;
  logic               collided;

  modport source (output valid, force_x, force_y, force_z, collided, input ready);
  modport sink   (input valid, force_x, force_y, force_z, collided, output ready);
endinterface

FILE: rtl/pcsf_cfg_if.sv
// ----------------------------------------------------------------------------
// pcsf_cfg_if
// Configuration write channel for the spring constant.
// ----------------------------------------------------------------------------
interface pcsf_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

FILE: rtl/pcsf_sqrt_stage.sv
// ----------------------------------------------------------------------------
// pcsf_sqrt_stage
// One registered step of the digit-by-digit square root: two radicand bits
// in, one root bit out.
// ----------------------------------------------------------------------------
module pcsf_sqrt_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  pcsf_pkg::sqrt_t step_i,
  output logic            valid_o,
  output pcsf_pkg::sqrt_t step_o
);
  import pcsf_pkg::*;

  logic [REMW+1:0] trial;
  logic [REMW+1:0] shifted;
  logic [REMW+1:0] diff;
  logic            take;
  sqrt_t           step_d;
  logic            valid_q;
  sqrt_t           step_q;

  // Bring down two radicand bits and try the next root bit.
  always_comb begin
    shifted = {step_i.rem, step_i.rad[SW-1 -: 2]};
    trial   = {{(REMW - ROOTW){1'b0}}, step_i.root, 2'b01};
    take    = shifted >= trial;
    diff    = shifted - trial;
    step_d       = step_i;
    step_d.rad   = {step_i.rad[SW-3:0], 2'b00};
    step_d.root  = {step_i.root[ROOTW-2:0], take};
    step_d.rem   = take ? diff[REMW-1:0] : shifted[REMW-1:0];
  end

  // Valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // Data.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      step_q <= step_d;
    end
  end

  assign valid_o = valid_q;
  assign step_o  = step_q;
endmodule

FILE: rtl/pcsf_div_stage.sv
// ----------------------------------------------------------------------------
// pcsf_div_stage
// One registered step of the three restoring dividers that form the unit
// vector: one quotient bit per lane.
// ----------------------------------------------------------------------------
module pcsf_div_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  pcsf_pkg::div_t step_i,
  output logic           valid_o,
  output pcsf_pkg::div_t step_o
);
  import pcsf_pkg::*;

  logic [2:0][DREMW:0] shifted;
  logic [2:0][DREMW:0] diff;
  logic [2:0]          take;
  div_t                step_d;
  logic                valid_q;
  div_t                step_q;

  // Shift in the next numerator bit and subtract the distance when it fits.
  always_comb begin
    step_d = step_i;
    for (int i = 0; i < 3; i++) begin
      shifted[i] = {step_i.rem[i], step_i.rest[i][DRESTW-1]};
      take[i]    = shifted[i] >= {2'b00, step_i.span};
      diff[i]    = shifted[i] - {2'b00, step_i.span};
      step_d.rem[i]  = take[i] ? diff[i][DREMW-1:0] : shifted[i][DREMW-1:0];
      step_d.rest[i] = {step_i.rest[i][DRESTW-2:0], 1'b0};
      step_d.quo[i]  = {step_i.quo[i][UW-2:0], take[i]};
    end
  end

  // Valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // Data.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      step_q <= step_d;
    end
  end

  assign valid_o = valid_q;
  assign step_o  = step_q;
endmodule

FILE: rtl/pair_contact_spring_force.sv
// ----------------------------------------------------------------------------
// pair_contact_spring_force
// Linear spring contact force between two spheres, one pair per cycle while force_o is not stalled.
// ----------------------------------------------------------------------------
// Usage:
//   pair_i carries one particle pair per transaction: both centroids and both
//   radii in signed or unsigned Q16.16. force_o returns one result for each
//   pair, in order: the saturated Q16.16 force on particle one and the
//   collided flag. cfg_i writes the spring constant k (unsigned Q16.16); it
//   is always ready, and the user must write it only while the pipeline is
//   empty; the block itself does not enforce this. It accepts one pair per
//   cycle unless force_o stalls. The depth comes from the 33 root steps
//   of the distance and the 31 quotient steps of the unit vector, each one
//   register stage, plus the offset, square, overlap and product stages.
//   The whole pipeline advances together: when force_o holds a result that
//   is not taken, every stage holds and pair_i.ready drops, so nothing is
//   lost or repeated. Reset clears all valid bits and sets k to 1.0; no
//   clearing pass is needed.
// ----------------------------------------------------------------------------
module pair_contact_spring_force (
  input  logic       clk_i,
  input  logic       rst_ni,
  pcsf_pair_if.sink  pair_i,
  pcsf_cfg_if.sink   cfg_i,
  pcsf_force_if.source force_o
);
  import pcsf_pkg::*;

  logic en;

  // Spring constant register.
  logic [KW-1:0] spring_q;
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spring_q <= SPRING_RESET;
    end else if (cfg_i.valid) begin
      spring_q <= cfg_i.data;
    end
  end

  // Global advance: move on unless a finished result is held.
  logic out_valid_q;
  assign en           = !out_valid_q || force_o.ready;
  assign pair_i.ready = en;

  // Front stage: offsets, magnitudes, signs and radius sum.
  logic signed [MW-1:0] dv [3];
  geom_t                geom1_d;
  always_comb begin
    dv[0] = {pair_i.second_x[CW-1], pair_i.second_x} - {pair_i.first_x[CW-1], pair_i.first_x};
    dv[1] = {pair_i.second_y[CW-1], pair_i.second_y} - {pair_i.first_y[CW-1], pair_i.first_y};
    if (DIMENSIONS == 2) begin
      dv[2] = '0;
    end else begin
      dv[2] = {pair_i.second_z[CW-1], pair_i.second_z}
            - {pair_i.first_z[CW-1], pair_i.first_z};
    end
    for (int i = 0; i < 3; i++) begin
      geom1_d.mag[i] = dv[i][MW-1] ? MW'(-dv[i]) : MW'(dv[i]);
      geom1_d.neg[i] = !dv[i][MW-1] && (dv[i] != '0);
    end
    geom1_d.rsum = {1'b0, pair_i.first_radius} + {1'b0, pair_i.second_radius};
  end

  logic  v1_q, v2_q, v3_q;
  geom_t geom1_q, geom2_q;
  logic [2:0][SW-1:0] sq2_q;
  sqrt_t sqrt_pipe [SQRT_STEPS+1];
  logic  sqrt_valid [SQRT_STEPS+1];

  // Valid bits of the front stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= pair_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Offsets, then squares, then the sum that seeds the root.
  always_ff @(posedge clk_i) begin
    if (en) begin
      geom1_q <= geom1_d;
      geom2_q <= geom1_q;
      for (int i = 0; i < 3; i++) begin
        sq2_q[i] <= geom1_q.mag[i] * geom1_q.mag[i];
      end
      sqrt_pipe[0].geom <= geom2_q;
      sqrt_pipe[0].rad  <= sq2_q[0] + sq2_q[1] + sq2_q[2];
      sqrt_pipe[0].root <= '0;
      sqrt_pipe[0].rem  <= '0;
    end
  end
  assign sqrt_valid[0] = v3_q;

  // Square root chain.
  for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
    pcsf_sqrt_stage u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (sqrt_valid[g]),
      .step_i  (sqrt_pipe[g]),
      .valid_o (sqrt_valid[g+1]),
      .step_o  (sqrt_pipe[g+1])
    );
  end

  // Overlap stage: sign of delta and its magnitude.
  logic [ROOTW+1:0] delta;
  always_comb begin
    delta = {2'b00, sqrt_pipe[SQRT_STEPS].root}
          - {{(ROOTW + 1 - RW){1'b0}}, sqrt_pipe[SQRT_STEPS].geom.rsum};
  end

  logic               ve1_q;
  logic [2:0][MW-1:0] e1_mag_q;
  logic [2:0]         e1_neg_q;
  logic [ROOTW-1:0]   e1_dist_q;
  logic [KW-1:0]      e1_dmag_q;
  logic               e1_coll_q;
  logic [ROOTW+1:0]   neg_delta;
  assign neg_delta = -delta;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ve1_q <= 1'b0;
    end else if (en) begin
      ve1_q <= sqrt_valid[SQRT_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e1_mag_q  <= sqrt_pipe[SQRT_STEPS].geom.mag;
      e1_neg_q  <= sqrt_pipe[SQRT_STEPS].geom.neg;
      e1_dist_q <= sqrt_pipe[SQRT_STEPS].root;
      e1_dmag_q <= neg_delta[KW-1:0];
      e1_coll_q <= delta[ROOTW+1];
    end
  end

  // Stiffness product and divider seeds.
  div_t div_pipe [DIV_STEPS+1];
  logic div_valid [DIV_STEPS+1];
  logic ve2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ve2_q <= 1'b0;
    end else if (en) begin
      ve2_q <= ve1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        div_pipe[0].rem[i]  <= {2'b00, e1_mag_q[i][MW-1:1]};
        div_pipe[0].rest[i] <= {e1_mag_q[i][0], {(DRESTW-1){1'b0}}};
        div_pipe[0].quo[i]  <= '0;
      end
      div_pipe[0].span     <= e1_dist_q;
      div_pipe[0].pmag     <= e1_dmag_q * spring_q;
      div_pipe[0].neg      <= e1_neg_q;
      div_pipe[0].collided <= e1_coll_q;
      div_pipe[0].zero     <= !e1_coll_q || (e1_dist_q == '0);
    end
  end
  assign div_valid[0] = ve2_q;

  // Unit vector dividers.
  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
    pcsf_div_stage u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (div_valid[g]),
      .step_i  (div_pipe[g]),
      .valid_o (div_valid[g+1]),
      .step_o  (div_pipe[g+1])
    );
  end

  // Product stages: partial products, full sum, then saturation.
  div_t               dlast;
  assign dlast = div_pipe[DIV_STEPS];

  logic               vm1_q, vm2_q;
  logic [2:0][PPW-1:0] pl_q, ph_q;
  logic [2:0]          m1_neg_q, m2_neg_q;
  logic                m1_coll_q, m2_coll_q, m1_zero_q, m2_zero_q;
  logic [2:0][QW-1:0]  q2_q;
  logic [2:0][FPW-1:0] full;
  logic [2:0][CW-1:0]  res;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      full[i] = {ph_q[i], {KW{1'b0}}} + {{KW{1'b0}}, pl_q[i]};
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (m2_zero_q) begin
        res[i] = '0;
      end else if (m2_neg_q[i]) begin
        res[i] = (q2_q[i] > NEG_LIMIT) ? NEG_LIMIT[CW-1:0] : CW'(-q2_q[i]);
      end else begin
        res[i] = (q2_q[i] > POS_LIMIT) ? POS_LIMIT[CW-1:0] : q2_q[i][CW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm1_q       <= 1'b0;
      vm2_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vm1_q       <= div_valid[DIV_STEPS];
      vm2_q       <= vm1_q;
      out_valid_q <= vm2_q;
    end
  end

  logic [2:0][CW-1:0] force_q;
  logic               coll_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pl_q[i] <= dlast.pmag[KW-1:0] * dlast.quo[i];
        ph_q[i] <= dlast.pmag[PW-1:KW] * dlast.quo[i];
        q2_q[i] <= full[i][FPW-1 -: QW];
      end
      m1_neg_q  <= dlast.neg;
      m1_coll_q <= dlast.collided;
      m1_zero_q <= dlast.zero;
      m2_neg_q  <= m1_neg_q;
      m2_coll_q <= m1_coll_q;
      m2_zero_q <= m1_zero_q;
      force_q   <= res;
      coll_q    <= m2_coll_q;
    end
  end

  // Result channel.
  assign force_o.valid    = out_valid_q;
  assign force_o.force_x  = force_q[0];
  assign force_o.force_y  = force_q[1];
  assign force_o.force_z  = force_q[2];
  assign force_o.collided = coll_q;

endmodule

FILE: rtl/pcsf_checker.sv
// ----------------------------------------------------------------------------
// pcsf_checker
// Port-level checks of the contact force pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module pcsf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] force_x_i,
  input logic [31:0] force_y_i,
  input logic [31:0] force_z_i,
  input logic        collided_i
);

  // A held result keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(force_x_i)
      && $stable(force_y_i) && $stable(force_z_i) && $stable(collided_i))
    else $error("held result changed");

  // Without contact the force is zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !collided_i |-> force_x_i == '0 && force_y_i == '0 && force_z_i == '0)
    else $error("force without contact");

  // The pipeline takes pairs exactly when its output stage can move.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i == (!out_valid_i || out_ready_i))
    else $error("input ready does not follow output stall");

  // No result leaves right after reset.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!rst_ni) |-> !out_valid_i)
    else $error("result right after reset");

endmodule

bind pair_contact_spring_force pcsf_checker u_pcsf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (pair_i.ready),
  .out_valid_i (force_o.valid),
  .out_ready_i (force_o.ready),
  .force_x_i   (force_o.force_x),
  .force_y_i   (force_o.force_y),
  .force_z_i   (force_o.force_z),
  .collided_i  (force_o.collided)
);
